@@ sv/pctdec_pkg.sv @@
// Shared types and constants for the percent-escape decoder.
// No dependencies; the front end, queue, back end, top level and testbench import this package.
package pctdec_pkg;

   localparam logic [7:0]  PERCENT_CHAR  = 8'h25;
   localparam logic [15:0] CAP_RESET     = 16'd256;
   localparam int          QUEUE_DEPTH   = 4;
   localparam int          QPTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int          GROUP_MAX     = 3;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [15:0] out_index;
      logic        out_last;
      logic        out_truncated;
   } rsp_payload_type;

   // Bytes produced by one accepted input item, oldest in slot 0.
   typedef struct packed {
      logic [1:0]                      count;
      logic [GROUP_MAX-1:0][7:0]       bytes;
      logic                            last;
   } group_type;

   // Queue head as seen by the back end.
   typedef struct packed {
      logic      valid;
      group_type group;
   } queue_head_type;

   // {is_hex, nibble}
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'b0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

endpackage

@@ sv/pctdec_stream_if.sv @@
// Valid/ready stream interface with a typed payload.
// Payload type is supplied by the instantiating level (see pctdec_pkg).
interface pctdec_stream_if #(
   parameter type payload_type = logic [7:0]
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/pctdec_front.sv @@
// Front end: holds escape lookahead and turns each input byte into a group of 0..3 bytes.
// Depends on pctdec_pkg and pctdec_stream_if.
module pctdec_front (
   input  logic                 clock,
   input  logic                 reset,
   pctdec_stream_if.sink        req_chan,
   input  logic                 queue_full,
   output logic                 push_valid,
   output pctdec_pkg::group_type push_group
);
   import pctdec_pkg::*;

   logic [1:0] held_count_ff, held_count_in;
   logic [7:0] held_hex_ff, held_hex_in;
   logic       accept;

   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      logic [7:0] b;
      logic [4:0] hb;
      logic [4:0] hh;
      logic [1:0] n;
      b  = req_chan.payload.in_byte;
      hb = hex_decode(b);
      hh = hex_decode(held_hex_ff);
      n  = 2'd0;
      push_group.bytes = '0;
      held_count_in = held_count_ff;
      held_hex_in   = held_hex_ff;

      case (held_count_ff)
         2'd1: begin
            if (hb[4]) begin
               held_count_in = 2'd2;
               held_hex_in   = b;
            end else begin
               push_group.bytes[0] = PERCENT_CHAR;
               n = 2'd1;
               if (b == PERCENT_CHAR) begin
                  held_count_in = 2'd1;
               end else begin
                  push_group.bytes[1] = b;
                  n = 2'd2;
                  held_count_in = 2'd0;
               end
            end
         end
         2'd2: begin
            if (hb[4]) begin
               push_group.bytes[0] = {hh[3:0], hb[3:0]};
               n = 2'd1;
               held_count_in = 2'd0;
            end else begin
               push_group.bytes[0] = PERCENT_CHAR;
               push_group.bytes[1] = held_hex_ff;
               n = 2'd2;
               if (b == PERCENT_CHAR) begin
                  held_count_in = 2'd1;
               end else begin
                  push_group.bytes[2] = b;
                  n = 2'd3;
                  held_count_in = 2'd0;
               end
            end
         end
         default: begin
            if (b == PERCENT_CHAR) begin
               held_count_in = 2'd1;
            end else begin
               push_group.bytes[0] = b;
               n = 2'd1;
               held_count_in = 2'd0;
            end
         end
      endcase

      // End of stream: flush whatever lookahead remains, literally.
      if (req_chan.payload.in_last) begin
         if (held_count_in != 2'd0) begin
            push_group.bytes[n] = PERCENT_CHAR;
            n = n + 2'd1;
         end
         if (held_count_in == 2'd2) begin
            push_group.bytes[n] = held_hex_in;
            n = n + 2'd1;
         end
         held_count_in = 2'd0;
      end

      push_group.count = n;
      push_group.last  = req_chan.payload.in_last;
      push_valid       = accept && (n != 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= 2'd0;
      end else if (accept) begin
         held_count_ff <= held_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_hex_ff <= held_hex_in;
      end
   end

endmodule

@@ sv/pctdec_queue.sv @@
// Short register queue of byte groups between front and back ends.
// Depends on pctdec_pkg.
module pctdec_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  pctdec_pkg::group_type     push_group,
   output logic                      full,
   input  logic                      pop,
   output pctdec_pkg::queue_head_type head
);
   import pctdec_pkg::*;

   group_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]   count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full       = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.group = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_BITS+1)'(do_push) - (QPTR_BITS+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_group;
      end
   end

endmodule

@@ sv/pctdec_back.sv @@
// Back end: serializes queued groups, numbers bytes, applies the capacity limit.
// Depends on pctdec_pkg and pctdec_stream_if.
module pctdec_back #(
   parameter int COUNT_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  pctdec_pkg::queue_head_type head,
   output logic                       pop,
   input  logic [15:0]                out_capacity,
   pctdec_stream_if.source            rsp_chan
);
   import pctdec_pkg::*;

   localparam int CMP_BITS = (COUNT_BITS + 1 > 16) ? COUNT_BITS + 1 : 16;

   logic [COUNT_BITS-1:0] written_ff, written_in;
   logic                  stopped_ff, stopped_in;
   logic [1:0]            slot_ff, slot_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   always_comb begin
      logic                  can_load;
      logic                  trunc;
      logic                  final_slot;
      logic [COUNT_BITS-1:0] next_count;
      can_load     = !rsp_valid_ff || rsp_chan.ready;
      next_count   = written_ff + 1'b1;
      trunc        = (CMP_BITS'(next_count) + 1'b1) >= CMP_BITS'(out_capacity);
      final_slot   = (slot_ff == head.group.count - 2'd1);
      written_in   = written_ff;
      stopped_in   = stopped_ff;
      slot_in      = slot_ff;
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;

      if (head.valid) begin
         if (stopped_ff) begin
            // Discarding until end of stream.
            pop     = 1'b1;
            slot_in = 2'd0;
            if (head.group.last) begin
               stopped_in = 1'b0;
               written_in = '0;
            end
         end else if (can_load) begin
            rsp_valid_in              = 1'b1;
            rsp_data_in.out_byte      = head.group.bytes[slot_ff];
            rsp_data_in.out_index     = 16'(written_ff);
            rsp_data_in.out_last      = trunc || (head.group.last && final_slot);
            rsp_data_in.out_truncated = trunc;
            written_in                = next_count;
            if (final_slot || trunc) begin
               pop     = 1'b1;
               slot_in = 2'd0;
            end else begin
               slot_in = slot_ff + 2'd1;
            end
            if (head.group.last && (final_slot || trunc)) begin
               written_in = '0;
               stopped_in = 1'b0;
            end else if (trunc) begin
               stopped_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff   <= '0;
         stopped_ff   <= 1'b0;
         slot_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         written_ff   <= written_in;
         stopped_ff   <= stopped_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

endmodule

@@ sv/percent_escape_decoder.sv @@
// Top level of the percent-escape decoder: capacity register, front end, queue, back end.
// Depends on pctdec_pkg, pctdec_stream_if, pctdec_front, pctdec_queue, pctdec_back.
//
//   channel    direction  handshake       carries
//   req_chan   in         valid/ready     in_byte, in_last
//   rsp_chan   out        valid/ready     out_byte, out_index, out_last, out_truncated
//   csr_*      in         write enable    out_capacity (16 bits)
//
// One input byte is taken per cycle while the four-entry group queue has room.
// The back end sends one decoded byte per cycle while rsp_chan is ready; a step that flushes
// lookahead can queue up to three bytes, which drain at that rate.
// A result passes through a queue entry and the back end's output register before transfer.
// Reset is synchronous and clears all control state; capacity returns to 256.
module percent_escape_decoder #(
   parameter int COUNT_BITS = 16
) (
   input  logic            clock,
   input  logic            reset,
   pctdec_stream_if.sink   req_chan,
   pctdec_stream_if.source rsp_chan,
   input  logic            csr_write_en,
   input  logic [15:0]     csr_write_data
);
   import pctdec_pkg::*;

   logic [15:0]    capacity_ff;
   logic           push_valid;
   group_type      push_group;
   logic           queue_full;
   logic           pop;
   queue_head_type head;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_write_en) begin
         capacity_ff <= csr_write_data;
      end
   end

   pctdec_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_group (push_group)
   );

   pctdec_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_group (push_group),
      .full       (queue_full),
      .pop        (pop),
      .head       (head)
   );

   pctdec_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .pop          (pop),
      .out_capacity (capacity_ff),
      .rsp_chan     (rsp_chan)
   );

endmodule

@@ tb/percent_escape_decoder_tb.sv @@
// Self-checking testbench for percent_escape_decoder: directed and random escaped streams,
// capacity settings and output back-pressure, checked against an in-bench decoder.
// Depends on pctdec_pkg, pctdec_stream_if and the percent_escape_decoder RTL.
module percent_escape_decoder_tb;
   import pctdec_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int PRINT_LIMIT    = 50;

   logic        clock;
   logic        reset;
   logic        csr_write_en;
   logic [15:0] csr_write_data;

   pctdec_stream_if #(.payload_type(req_payload_type)) req_chan ();
   pctdec_stream_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   percent_escape_decoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // decoder state mirrored by the bench
   logic [15:0] capacity;
   logic [7:0]  held_q [2];
   int          held_n;
   logic [15:0] written_n;
   logic        discarding;

   rsp_payload_type pending_bytes [$];
   rsp_payload_type head;

   int error_count   = 0;
   int quiet_cycles  = 0;
   int burst_left    = 0;
   bit sender_bursty = 0;
   int rsp_stall_level = 0;
   int rsp_hold_cycles = 0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int hex_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
   endfunction

   function automatic logic [7:0] random_hex_char();
      int d;
      d = $urandom_range(0, 15);
      if (d < 10) return 8'(int'("0") + d);
      if ($urandom_range(0, 1)) return 8'(int'("a") + d - 10);
      return 8'(int'("A") + d - 10);
   endfunction

   function automatic logic [7:0] random_non_hex();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      while (hex_value(c) >= 0) c = 8'($urandom_range(0, 255));
      return c;
   endfunction

   function automatic void clear_stream();
      held_q[0]  = 8'h00;
      held_q[1]  = 8'h00;
      held_n     = 0;
      written_n  = 16'd0;
      discarding = 1'b0;
   endfunction

   // Work out the decoded bytes caused by one input transfer.
   function automatic void decode_byte(logic [7:0] b, logic last);
      logic [7:0]      scan [3];
      logic [7:0]      emit [3];
      int              len;
      int              np;
      int              i;
      int              k;
      int              hi;
      int              lo;
      logic            trunc;
      rsp_payload_type r;
      len = 0;
      np  = 0;
      i   = 0;
      if (discarding) begin
         if (last) clear_stream();
         return;
      end
      for (k = 0; k < held_n; k++) begin
         scan[len] = held_q[k];
         len++;
      end
      scan[len] = b;
      len++;
      while (i < len) begin
         if (scan[i] != PERCENT_CHAR) begin
            emit[np] = scan[i];
            np++;
            i++;
            continue;
         end
         if (i + 1 >= len) break;
         hi = hex_value(scan[i + 1]);
         if (hi < 0) begin
            emit[np] = scan[i];
            np++;
            i++;
            continue;
         end
         if (i + 2 >= len) break;
         lo = hex_value(scan[i + 2]);
         if (lo < 0) begin
            emit[np] = scan[i];
            np++;
            i++;
            continue;
         end
         emit[np] = 8'(hi * 16 + lo);
         np++;
         i += 3;
      end
      // unresolved '%' prefix waits for lookahead
      held_n = 0;
      while (i < len && held_n < 2) begin
         held_q[held_n] = scan[i];
         held_n++;
         i++;
      end
      if (last) begin
         for (k = 0; k < held_n && np < 3; k++) begin
            emit[np] = held_q[k];
            np++;
         end
         held_n = 0;
      end
      for (k = 0; k < np; k++) begin
         r.out_byte  = emit[k];
         r.out_index = written_n;
         written_n   = written_n + 16'd1;
         trunc       = (32'(written_n) + 32'd1) >= 32'(capacity);
         r.out_last      = trunc || (last && k == np - 1);
         r.out_truncated = trunc;
         pending_bytes.push_back(r);
         if (trunc) begin
            discarding = 1'b1;
            held_n     = 0;
            break;
         end
      end
      if (last) clear_stream();
   endfunction

   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_LIMIT) $display("%0t: MISMATCH %s", $time, msg);
      error_count++;
   endtask

   // Offer one item and wait for its transfer; bursty mode inserts random gaps.
   task automatic send_item(input logic [7:0] b, input logic last);
      int gap;
      if (sender_bursty) begin
         if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
            burst_left = $urandom_range(1, 10);
         end
         burst_left--;
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= {b, last};
      do @(posedge clock); while (!req_chan.ready);
      decode_byte(b, last);
   endtask

   task automatic send_text(input string s, input logic close);
      int i;
      for (i = 0; i < s.len(); i++) send_item(s[i], close && (i == s.len() - 1));
   endtask

   task automatic pause_until_drained();
      req_chan.valid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      // discarded input makes no result but may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [15:0] value);
      pause_until_drained();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      capacity = value;
      csr_write_en <= 1'b0;
   endtask

   // Mostly well-formed escapes, with literal bytes and broken escapes mixed in.
   task automatic send_random_stream(input int n);
      logic [7:0] text [$];
      int         pick;
      int         i;
      while (text.size() < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            text.push_back(PERCENT_CHAR);
            text.push_back(random_hex_char());
            text.push_back(random_hex_char());
         end else if (pick < 75) begin
            text.push_back(8'($urandom_range(0, 255)));
         end else if (pick < 85) begin
            text.push_back(PERCENT_CHAR);
            text.push_back(random_non_hex());
         end else if (pick < 95) begin
            text.push_back(PERCENT_CHAR);
            text.push_back(random_hex_char());
            text.push_back(random_non_hex());
         end else begin
            text.push_back(PERCENT_CHAR);
         end
      end
      while (text.size() > n) void'(text.pop_back());
      for (i = 0; i < n; i++) send_item(text[i], i == n - 1);
   endtask

   task automatic test_escape_decoding();
      send_text("%41%6f%C9%aB", 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b1);
   endtask

   task automatic test_malformed_escapes();
      send_text("%%4G%", 1'b1);
   endtask

   task automatic test_end_flush();
      send_text("%4", 1'b1);
      send_text("%", 1'b1);
   endtask

   task automatic test_capacity_limits();
      write_capacity(16'd2);
      send_text("ab", 1'b1);
      // input ends on the byte that fills the buffer
      write_capacity(16'd1);
      send_text("z", 1'b1);
      write_capacity(16'd0);
      send_text("q", 1'b1);
      // capacity reached inside a multi-byte flush drops the rest
      write_capacity(16'd3);
      send_text("x%4Z", 1'b1);
   endtask

   task automatic test_random_streams();
      logic [15:0] cap_choices [6];
      int          phase;
      int          sent;
      int          n;
      cap_choices = '{16'd2, 16'd3, 16'd5, 16'd0, 16'd256, 16'hFFFF};
      for (phase = 0; phase < 6; phase++) begin
         if (phase == 3) write_capacity(16'($urandom_range(4, 24)));
         else write_capacity(cap_choices[phase]);
         sender_bursty   = (phase != 4);
         rsp_stall_level = phase % 4;
         sent = 0;
         while (sent < 24) begin
            n = $urandom_range(1, 12);
            send_random_stream(n);
            sent += n;
         end
      end
   endtask

   task automatic test_output_backpressure();
      write_capacity(16'd256);
      sender_bursty   = 0;
      rsp_stall_level = 0;
      rsp_hold_cycles = 80;
      repeat (6) send_random_stream(4);
      pause_until_drained();
      rsp_stall_level = 3;
      sender_bursty   = 1;
      repeat (4) send_text("%4", 1'b1);
   endtask

   // Receiver: random ready runs, or a long hold-off when requested.
   initial begin
      int   run_left;
      logic run_ready;
      run_left  = 0;
      run_ready = 1'b1;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_chan.ready <= 1'b0;
         end else if (rsp_stall_level == 0) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            if (run_left == 0) begin
               run_ready = ($urandom_range(0, 9) >= 2 * rsp_stall_level);
               run_left  = $urandom_range(1, 2 + 2 * rsp_stall_level);
            end
            run_left--;
            rsp_chan.ready <= run_ready;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected result byte %02h index %0d",
               rsp_chan.payload.out_byte, rsp_chan.payload.out_index));
         end else begin
            head = pending_bytes.pop_front();
            if (rsp_chan.payload.out_byte !== head.out_byte)
               report_mismatch($sformatf("index %0d out_byte got %02h want %02h",
                  head.out_index, rsp_chan.payload.out_byte, head.out_byte));
            if (rsp_chan.payload.out_index !== head.out_index)
               report_mismatch($sformatf("out_index got %0d want %0d",
                  rsp_chan.payload.out_index, head.out_index));
            if (rsp_chan.payload.out_last !== head.out_last)
               report_mismatch($sformatf("index %0d out_last got %b want %b",
                  head.out_index, rsp_chan.payload.out_last, head.out_last));
            if (rsp_chan.payload.out_truncated !== head.out_truncated)
               report_mismatch($sformatf("index %0d out_truncated got %b want %b",
                  head.out_index, rsp_chan.payload.out_truncated, head.out_truncated));
         end
      end
   end

   // Ends the run when no transfer happens on either channel for too long.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      csr_write_en     <= 1'b0;
      csr_write_data   <= 16'd0;
      capacity = CAP_RESET;
      clear_stream();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_escape_decoding();
      test_malformed_escapes();
      test_end_flush();
      test_capacity_limits();
      test_random_streams();
      test_output_backpressure();

      pause_until_drained();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/pctdec_pkg.sv
sv/pctdec_stream_if.sv
sv/pctdec_front.sv
sv/pctdec_queue.sv
sv/pctdec_back.sv
sv/percent_escape_decoder.sv
tb/percent_escape_decoder_tb.sv
